// File: rtl/skt_pkg.sv
// sorted key table package: command and status codes, input and result words
// no dependencies
`timescale 1ns / 1ps
package skt_pkg;
  localparam logic [1:0] CMD_LOOKUP  = 2'd0;
  localparam logic [1:0] CMD_INS_ABS = 2'd1;
  localparam logic [1:0] CMD_INS_ALW = 2'd2;
  localparam logic [1:0] CMD_COMPACT = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_COMPACTED = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [15:0] handle;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    logic [63:0] word_d;
  } skt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] position;
    logic [8:0] entry_total;
  } skt_out_t;

  // one table row: key, handle and the four payload words
  typedef struct packed {
    logic [63:0]  key;
    logic [15:0]  handle;
    logic [255:0] payload;
  } skt_row_t;
endpackage

// File: rtl/sorted_key_table.sv
// sorted key table top level: sequencer around one row memory
// depends on skt_pkg
`timescale 1ns / 1ps
// Takes one command at a time; busy is high from the accepting edge until the
// end of the result strobe. The result appears for one cycle on result_valid_o
// and cannot be stalled. A lookup runs up to s = ceil(log2(entries+1)) search
// steps, each a memory read and then a compare, then a final read of the
// candidate row, a decide state and the strobe. An insert then moves each entry
// above the insertion point up one row. A compact reads every stored entry in
// turn. All rows live in one memory with a separate read port and write port;
// the move loops read a row, then write it, one row at a time.
// No clearing pass.
module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  skt_in_t  cmd_i,
  output logic     result_valid_o,
  output skt_out_t result_o
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1) + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SRD = 3'd1, S_SCMP = 3'd2,
                         S_MRD = 3'd3, S_MWR = 3'd4, S_CRD = 3'd5,
                         S_CWR = 3'd6, S_DONE = 3'd7;

  skt_row_t mem [CAPACITY];
  skt_row_t rd_q;
  logic [AW-1:0] raddr, waddr;
  logic          re, we;
  skt_row_t      wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  logic [2:0]    state_q, state_d;
  skt_in_t       in_q;
  logic [CW-1:0] cnt_q, cnt_d, lo_q, lo_d, hi_q, hi_d, j_q, j_d, dst_q, dst_d;
  logic [CW-1:0] mid;
  logic [2:0]    st_q, st_d;
  logic [7:0]    pos_q, pos_d;
  logic          prs_q, prs_d;

  // lo is offset by one so -1 encodes as zero
  assign mid = CW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; lo_d = lo_q; hi_d = hi_q; j_d = j_q;
    dst_d = dst_q; st_d = st_q; pos_d = pos_q; prs_d = prs_q;
    re = 1'b0; we = 1'b0; raddr = '0; waddr = '0; wdata = rd_q;
    unique case (state_q)
      S_IDLE: if (start) begin
        if (cmd_i.cmd == CMD_COMPACT) begin
          j_d = '0; dst_d = '0; state_d = S_CRD;
        end else begin
          lo_d = '0; hi_d = cnt_q + CW'(1); state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (hi_q - lo_q > CW'(1)) begin
          re = 1'b1; raddr = AW'(mid - CW'(1)); state_d = S_SCMP;
        end else if (lo_q == '0) begin
          prs_d = 1'b0; state_d = S_MRD; j_d = cnt_q;
        end else begin
          re = 1'b1; raddr = AW'(lo_q - CW'(1)); state_d = S_SCMP;
          hi_d = lo_q; // marks final read
        end
      end
      S_SCMP: begin
        if (hi_q == lo_q) begin
          prs_d = (rd_q.key == in_q.key); state_d = S_MRD; j_d = cnt_q;
          hi_d = lo_q + CW'(1);
        end else if (in_q.key >= rd_q.key) begin
          lo_d = mid; state_d = S_SRD;
        end else begin
          hi_d = mid; state_d = S_SRD;
        end
        pos_d = 8'(lo_q - CW'(1));
      end
      S_MRD: begin
        // first entry into this state decides the command outcome
        if (in_q.cmd == CMD_LOOKUP || (in_q.cmd == CMD_INS_ABS && prs_q)) begin
          st_d = prs_q ? ST_FOUND : ST_NOT_FOUND;
          pos_d = prs_q ? 8'(lo_q - CW'(1)) : 8'd0;
          state_d = S_DONE;
        end else if (cnt_q >= CW'(CAPACITY)) begin
          st_d = ST_FULL; pos_d = '0; state_d = S_DONE;
        end else if (j_q > lo_q) begin
          re = 1'b1; raddr = AW'(j_q - CW'(1)); state_d = S_MWR;
        end else begin
          we = 1'b1; waddr = AW'(lo_q);
          wdata.key = in_q.key; wdata.handle = in_q.handle;
          wdata.payload = {in_q.word_d, in_q.word_c, in_q.word_b, in_q.word_a};
          cnt_d = cnt_q + CW'(1); st_d = ST_INSERTED; pos_d = 8'(lo_q);
          state_d = S_DONE;
        end
      end
      S_MWR: begin
        we = 1'b1; waddr = AW'(j_q); j_d = j_q - CW'(1); state_d = S_MRD;
      end
      S_CRD: begin
        if (j_q < cnt_q) begin
          re = 1'b1; raddr = AW'(j_q); state_d = S_CWR;
        end else begin
          cnt_d = dst_q; st_d = ST_COMPACTED; pos_d = '0; state_d = S_DONE;
        end
      end
      S_CWR: begin
        if (rd_q.handle != '0) begin
          we = 1'b1; waddr = AW'(dst_q); dst_d = dst_q + CW'(1);
        end
        j_d = j_q + CW'(1); state_d = S_CRD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) in_q <= cmd_i;
    lo_q <= lo_d; hi_q <= hi_d; j_q <= j_d; dst_q <= dst_d;
    st_q <= st_d; pos_q <= pos_d; prs_q <= prs_d;
  end

  assign busy = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign result_o.status = st_q;
  assign result_o.position = pos_q;
  assign result_o.entry_total = 9'(cnt_q);
endmodule
